[hw/rtl/sha_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

    localparam int unsigned ROUNDS = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        case (idx)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        round_k = k[idx];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[hw/rtl/sha_core.sv]
// Iterative SHA-256 compression: one round per cycle over a 16-word schedule window.
module sha_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [511:0]         block,
    input  logic                 reinit,
    output logic                 busy,
    output logic                 done,
    output logic [255:0]         hash
);
    import sha_pkg::*;

    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   rnd_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] wn;
    logic [31:0] s0;
    logic [31:0] s1;

    always_comb
    begin
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(rnd_reg) + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (reinit)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_hash(3'(i));
                end
            end
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= block[511 - 32 * i -: 32];
                end
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= wn;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_reg + 6'd1;
                if (rnd_reg == 6'(ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    h_reg[0] <= h_reg[0] + t1 + t2;
                    h_reg[1] <= h_reg[1] + v_reg[0];
                    h_reg[2] <= h_reg[2] + v_reg[1];
                    h_reg[3] <= h_reg[3] + v_reg[2];
                    h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                    h_reg[5] <= h_reg[5] + v_reg[4];
                    h_reg[6] <= h_reg[6] + v_reg[5];
                    h_reg[7] <= h_reg[7] + v_reg[6];
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            hash[255 - 32 * i -: 32] = h_reg[i];
        end
    end
endmodule

[hw/rtl/sha256_stream_hasher.sv]
// Top level of the SHA-256 byte stream hasher.
//  channel | dir | beat content
//  s_axis  | in  | one message byte, tlast = final item, tuser = no byte
//  m_axis  | out | one digest word, tlast = eighth word, tuser = word index
// A byte that fills a block hands it to the shared round unit (load, 64 rounds, done)
// before the next byte is taken; other bytes are taken without waiting.
// A final beat shifts in one pad byte per cycle up to the block end, then hashes each
// block; a fill past 55 bytes adds a second block of pad bytes.
// Reset clears control, count and hash state; the buffer is not cleared.
// A stalled output holds the current word; no input is taken until all eight leave.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // final_item
    input  logic        s_axis_tuser,   // no_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast,   // last_word
    output logic [2:0]  m_axis_tuser    // [2:0] word_index
);
    import sha_pkg::*;

    state_t       state_reg;
    state_t       state_next;
    logic [511:0] buf_reg;
    logic [60:0]  count_reg;
    logic         fin_reg;
    logic         second_reg;
    logic         mark_reg;
    logic [5:0]   slot_reg;
    logic [2:0]   widx_reg;
    logic         start;
    logic         reinit;
    logic         core_busy;
    logic         core_done;
    logic [255:0] hash;
    logic         acc;
    logic [60:0]  cnt_inc;
    logic [63:0]  bit_len;
    logic [7:0]   pad_byte;
    logic         shift_en;
    logic [7:0]   shift_byte;

    sha_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .block  (buf_reg),
        .reinit (reinit),
        .busy   (core_busy),
        .done   (core_done),
        .hash   (hash)
    );

    assign acc     = s_axis_tvalid && s_axis_tready;
    assign cnt_inc = count_reg + 61'd1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (!s_axis_tuser && cnt_inc[5:0] == 6'd0)
                        state_next = ST_COMP;
                    else if (s_axis_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (slot_reg == 6'd63)
                    state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (core_done)
                begin
                    if (fin_reg && !second_reg)
                        state_next = ST_PAD;
                    else if (fin_reg)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (m_axis_tready && widx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        start         = (state_reg == ST_COMP) && !core_busy && !core_done;
        reinit        = (state_reg == ST_EMIT) && m_axis_tready && widx_reg == 3'd7;
        m_axis_tvalid = (state_reg == ST_EMIT);
        m_axis_tdata  = hash[255 - 32 * widx_reg -: 32];
        m_axis_tuser  = widx_reg;
        m_axis_tlast  = (widx_reg == 3'd7);
        bit_len       = {count_reg, 3'b000};
        if (!mark_reg)
            pad_byte = 8'h80;
        else if (second_reg && slot_reg >= 6'd56)
            pad_byte = bit_len[63 - 8 * slot_reg[2:0] -: 8];
        else
            pad_byte = 8'h00;
        shift_en      = (acc && !s_axis_tuser) || (state_reg == ST_PAD);
        shift_byte    = (state_reg == ST_PAD) ? pad_byte : s_axis_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            mark_reg   <= 1'b0;
            slot_reg   <= '0;
            widx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        fin_reg    <= s_axis_tlast;
                        second_reg <= 1'b0;
                        mark_reg   <= 1'b0;
                        widx_reg   <= '0;
                        if (!s_axis_tuser)
                        begin
                            count_reg <= cnt_inc;
                            slot_reg  <= slot_reg + 6'd1;
                        end
                    end
                end
                ST_PAD:
                begin
                    slot_reg <= slot_reg + 6'd1;
                    mark_reg <= 1'b1;
                    if (!mark_reg && slot_reg < 6'd56)
                        second_reg <= 1'b1;
                end
                ST_COMP:
                begin
                    if (core_done && fin_reg && !second_reg)
                        second_reg <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (m_axis_tready)
                    begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7)
                        begin
                            count_reg <= '0;
                            fin_reg   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
            buf_reg <= {buf_reg[503:0], shift_byte};
    end
endmodule

[hw/rtl/sha_checker.sv]
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input ready during output");
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
        else $error("last flag mismatch");
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
        else $error("word index skipped");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled word changed");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
